>>> rtl/differential_drive_odometry_core_assert.svh
// assertion macros shared by the odometry core modules
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// check a property on every clock edge outside reset
`define DDO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every clock edge, reset included
`define DDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ddo_pkg.sv
// shared types, constants and tables for the odometry core
`timescale 1ns / 1ps

package ddo_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN     = 2'd1;

  // register reset values
  localparam logic [23:0] DISTANCE_RESET = 24'd3953;
  localparam logic [23:0] TURN_RESET     = 24'd357914;

  // rotation unit
  localparam int CORDIC_STEPS_DEFAULT = 24;
  localparam int CORDIC_W  = 34;
  localparam int ARC_DEPTH = 32;
  localparam int ARC_IDX_W = 5;
  localparam logic [CORDIC_W-1:0] GAIN_Q30 = 34'd652032874;

  // arctangent of 2^-i as a binary angle, full turn = 2^32
  localparam logic [29:0] ARC_TABLE [ARC_DEPTH] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41721,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,
    30'd41,        30'd20,        30'd10,        30'd5,
    30'd3,         30'd1,         30'd1,         30'd0
  };

  // result of the rotation unit back to the sequencer
  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;
  } cordic_res_t;

endpackage

>>> rtl/ddo_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module ddo_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  // one product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

>>> rtl/ddo_cordic.sv
// iterative rotation unit: cos and sin of a binary angle in Q2.30
`timescale 1ns / 1ps

module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          angle,
  output ddo_pkg::cordic_res_t res
);

  `include "differential_drive_odometry_core_assert.svh"

  localparam int StepW = $clog2(CORDIC_STEPS);
  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);

  logic                                busy;
  logic                                done;
  logic [StepW-1:0]                    step;
  logic [1:0]                          quad;
  logic signed [ddo_pkg::CORDIC_W-1:0] x;
  logic signed [ddo_pkg::CORDIC_W-1:0] y;
  logic signed [31:0]                  z;

  logic signed [ddo_pkg::CORDIC_W-1:0] x_shift;
  logic signed [ddo_pkg::CORDIC_W-1:0] y_shift;
  logic signed [31:0]                  arc;

  // shared shifter and arc lookup for the current step
  assign x_shift = x >>> step;
  assign y_shift = y >>> step;
  assign arc     = $signed({2'b00, ddo_pkg::ARC_TABLE[ddo_pkg::ARC_IDX_W'(step)]});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // rotation datapath, one micro-rotation a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= ddo_pkg::GAIN_Q30;
      y    <= '0;
      z    <= $signed({2'b00, angle[29:0]});
      quad <= angle[31:30];
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - y_shift;
        y <= y + x_shift;
        z <= z - arc;
      end else begin
        x <= x + y_shift;
        y <= y - x_shift;
        z <= z + arc;
      end
    end
  end

  // quadrant fold by swap and negate
  always_comb begin
    res.done = done;
    unique case (quad)
      2'd0: begin
        res.cos_q30 = x[31:0];
        res.sin_q30 = y[31:0];
      end
      2'd1: begin
        res.cos_q30 = -y[31:0];
        res.sin_q30 = x[31:0];
      end
      2'd2: begin
        res.cos_q30 = -x[31:0];
        res.sin_q30 = -y[31:0];
      end
      default: begin
        res.cos_q30 = y[31:0];
        res.sin_q30 = -x[31:0];
      end
    endcase
  end

  `DDO_ASSERT(a_start_when_idle, clk, rst, start |-> !busy, "rotation started while busy")
  `DDO_ASSERT(a_done_after_last, clk, rst, (busy && !start && step == LastStep) |=> (done && !busy), "no done after last step")
  `DDO_ASSERT(a_done_single, clk, rst, done |=> !done, "done held longer than one cycle")

endmodule

>>> rtl/differential_drive_odometry_core.sv
// Differential drive wheel odometry: each word of left and right encoder
// deltas advances the heading (binary angle, full turn = 2^32) by
// (right - left) * turn_per_count and moves the saturating Q16.16 x/y pose by
// the travel (left + right) / 2 * distance_per_count along the new heading.
// One result word follows every input word. A new word is accepted only
// after the previous result has been loaded into the output register, and
// the rotation unit in between does one micro-rotation per cycle and then
// raises its done strobe, which the sequencer waits for. One shared 32x32
// multiplier is used in turn for heading,
// travel, x, y and the tenths of a degree. in_ready is high only while the
// sequencer is idle. A finished result waits in the output register while
// the next word is accepted. If that register still holds an unread word
// when the next result is finished, the sequencer stays on it until the sink
// takes the old word, so a stalled sink adds its stall cycles to the item.
// Configuration writes are always taken and must only happen while idle.
`timescale 1ns / 1ps

module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]                     cfg_data,
  // encoder words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              left_count,
  input  logic signed [15:0]              right_count,
  // pose words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              x_position,
  output logic signed [31:0]              y_position,
  output logic [31:0]                     heading_turn,
  output logic signed [11:0]              heading_tenths
);

  `include "differential_drive_odometry_core_assert.svh"

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MTURN  = 4'd1;
  localparam logic [3:0] S_MTRAV  = 4'd2;
  localparam logic [3:0] S_CSTART = 4'd3;
  localparam logic [3:0] S_CORDIC = 4'd4;
  localparam logic [3:0] S_MX     = 4'd5;
  localparam logic [3:0] S_MY     = 4'd6;
  localparam logic [3:0] S_MTEN   = 4'd7;
  localparam logic [3:0] S_TEN    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic signed [63:0] HALF_Q9    = 64'sd256;
  localparam logic signed [63:0] HALF_Q30   = 64'sd536870912;
  localparam logic signed [63:0] HALF_Q32   = 64'sd2147483648;
  localparam logic signed [31:0] TENTHS_TURN = 32'sd3600;
  localparam logic signed [11:0] TENTHS_HALF = 12'sd1800;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [23:0]        distance_per_count;
  logic [23:0]        turn_per_count;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0]        pose_heading;
  logic signed [16:0] diff;
  logic signed [16:0] sum;
  logic signed [31:0] travel;
  logic signed [11:0] tenths;

  logic               mul_en;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_q9;
  logic signed [63:0] prod_q30;
  logic signed [63:0] prod_q32;
  logic signed [34:0] pose_sum_x;
  logic signed [34:0] pose_sum_y;
  logic signed [11:0] tenths_raw;
  logic               cordic_start;
  logic               out_load;
  ddo_pkg::cordic_res_t cres;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_count <= ddo_pkg::DISTANCE_RESET;
      turn_per_count     <= ddo_pkg::TURN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ddo_pkg::REG_DISTANCE: distance_per_count <= cfg_data;
        ddo_pkg::REG_TURN:     turn_per_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  assign in_ready     = (state == S_IDLE);
  assign cordic_start = (state == S_CSTART);
  assign out_load     = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_MTURN;
      S_MTURN:  state_next = S_MTRAV;
      S_MTRAV:  state_next = S_CSTART;
      S_CSTART: state_next = S_CORDIC;
      S_CORDIC: if (cres.done) state_next = S_MX;
      S_MX:     state_next = S_MY;
      S_MY:     state_next = S_MTEN;
      S_MTEN:   state_next = S_TEN;
      S_TEN:    state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_MTURN: begin
        mul_a = 32'(diff);
        mul_b = $signed({8'd0, turn_per_count});
      end
      S_MTRAV: begin
        mul_a = 32'(sum);
        mul_b = $signed({8'd0, distance_per_count});
      end
      S_MX: begin
        mul_a = travel;
        mul_b = cres.cos_q30;
      end
      S_MY: begin
        mul_a = travel;
        mul_b = cres.sin_q30;
      end
      S_MTEN: begin
        mul_a = $signed(pose_heading);
        mul_b = TENTHS_TURN;
      end
      default: mul_en = 1'b0;
    endcase
  end

  ddo_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (pose_heading),
    .res   (cres)
  );

  // rounding of the product, ties toward plus infinity
  assign prod_q9    = prod + HALF_Q9;
  assign prod_q30   = prod + HALF_Q30;
  assign prod_q32   = prod + HALF_Q32;
  assign pose_sum_x = {{3{pose_x[31]}}, pose_x} + {prod_q30[63], prod_q30[63:30]};
  assign pose_sum_y = {{3{pose_y[31]}}, pose_y} + {prod_q30[63], prod_q30[63:30]};
  assign tenths_raw = prod_q32[43:32];

  // pose update
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      unique case (state)
        S_MTRAV: pose_heading <= pose_heading + prod[31:0];
        S_MY:    pose_x       <= sat32(pose_sum_x);
        S_MTEN:  pose_y       <= sat32(pose_sum_y);
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      diff <= 17'(right_count) - 17'(left_count);
      sum  <= 17'(right_count) + 17'(left_count);
    end
    if (state == S_CSTART) begin
      travel <= prod_q9[40:9];
    end
    if (state == S_TEN) begin
      tenths <= (tenths_raw == TENTHS_HALF) ? -TENTHS_HALF : tenths_raw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      x_position     <= pose_x;
      y_position     <= pose_y;
      heading_turn   <= pose_heading;
      heading_tenths <= tenths;
    end
  end

  `DDO_ASSERT(a_busy_after_accept, clk, rst,
    (in_valid && in_ready) |=> !in_ready, "ready right after accept")
  `DDO_ASSERT(a_result_loaded, clk, rst, out_load |=> out_valid,
    "result not presented after load")
  `DDO_ASSERT(a_tenths_range, clk, rst,
    out_valid |-> (heading_tenths >= -TENTHS_HALF && heading_tenths < TENTHS_HALF),
    "tenths out of range")
  `DDO_ASSERT(a_cordic_done_state, clk, rst, cres.done |-> (state == S_CORDIC),
    "rotation done outside wait state")

endmodule

>>> sim/odometry_pose_checker.sv
// pose checker: watches the odometry channels, predicts every pose word and compares it
`timescale 1ns / 1ps

module odometry_pose_checker #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]                     cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [15:0]              left_count,
  input  logic signed [15:0]              right_count,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic signed [31:0]              x_position,
  input  logic signed [31:0]              y_position,
  input  logic [31:0]                     heading_turn,
  input  logic signed [11:0]              heading_tenths,
  output int                              fail_count,
  output int                              outstanding
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        heading;
    logic signed [11:0] tenths;
  } pose_word_t;

  // predicted pose and register copies
  logic [23:0]        dist_q;
  logic [23:0]        turn_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic [31:0]        heading_q;

  pose_word_t expected_poses[$];

  initial fail_count = 0;
  initial outstanding = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // iterative rotation over the residual quarter-turn angle, quadrant applied exactly
  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    longint cx;
    longint cy;
    longint cz;
    longint tx;
    longint ty;
    int     n;
    int     i;
    cx = longint'(ddo_pkg::GAIN_Q30);
    cy = 0;
    cz = longint'(ang[29:0]);
    n = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    for (i = 0; i < n; i++) begin
      tx = cy >>> i;
      ty = cx >>> i;
      if (cz >= 0) begin
        cx = cx - tx;
        cy = cy + ty;
        cz = cz - longint'(ddo_pkg::ARC_TABLE[i]);
      end else begin
        cx = cx + tx;
        cy = cy - ty;
        cz = cz + longint'(ddo_pkg::ARC_TABLE[i]);
      end
    end
    case (ang[31:30])
      2'd0: begin c = cx; s = cy; end
      2'd1: begin c = -cy; s = cx; end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endfunction

  // advance the predicted pose by one encoder word
  function automatic pose_word_t advance_pose(input logic signed [15:0] l,
                                              input logic signed [15:0] r);
    pose_word_t res;
    longint     lft;
    longint     rgt;
    longint     travel;
    longint     c;
    longint     s;
    longint     hs;
    longint     tenths;
    lft = longint'(l);
    rgt = longint'(r);
    heading_q = heading_q + 32'((rgt - lft) * longint'(turn_q));
    travel = ((lft + rgt) * longint'(dist_q) + (longint'(1) <<< 8)) >>> 9;
    rotate_unit(heading_q, c, s);
    x_q = clamp32(longint'(x_q) + ((travel * c + (longint'(1) <<< 29)) >>> 30));
    y_q = clamp32(longint'(y_q) + ((travel * s + (longint'(1) <<< 29)) >>> 30));
    hs = longint'($signed(heading_q));
    tenths = (hs * 3600 + (longint'(1) <<< 31)) >>> 32;
    if (tenths >= 1800) tenths = -1800;
    res.x = x_q;
    res.y = y_q;
    res.heading = heading_q;
    res.tenths = 12'(tenths);
    return res;
  endfunction

  // sample all channels at the edge, then predict and compare
  always @(posedge clk) begin
    pose_word_t want;
    if (rst) begin
      dist_q = ddo_pkg::DISTANCE_RESET;
      turn_q = ddo_pkg::TURN_RESET;
      x_q = '0;
      y_q = '0;
      heading_q = '0;
      expected_poses.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ddo_pkg::REG_DISTANCE: dist_q = cfg_data;
          ddo_pkg::REG_TURN:     turn_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          report("pose word with nothing expected");
        end else begin
          want = expected_poses.pop_front();
          if (x_position !== want.x)
            report($sformatf("x_position got %0d expected %0d", x_position, want.x));
          if (y_position !== want.y)
            report($sformatf("y_position got %0d expected %0d", y_position, want.y));
          if (heading_turn !== want.heading)
            report($sformatf("heading_turn got %0h expected %0h", heading_turn,
                             want.heading));
          if (heading_tenths !== want.tenths)
            report($sformatf("heading_tenths got %0d expected %0d", heading_tenths,
                             want.tenths));
        end
      end
      if (in_valid && in_ready)
        expected_poses.push_back(advance_pose(left_count, right_count));
      outstanding <= expected_poses.size();
    end
  end

endmodule

>>> sim/testbench.sv
// top of the odometry regression: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

  // indexes past the register list, writes there are dropped
  localparam logic [ddo_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ddo_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [23:0] REG_MAX = 24'hffffff;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 150;
  localparam int HOLD_AT_RESULT = 700;
  localparam int HOLD_CYCLES = 300;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [23:0]                     cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic signed [15:0]              left_count;
  logic signed [15:0]              right_count;
  logic                            out_valid;
  logic                            out_ready;
  logic signed [31:0]              x_position;
  logic signed [31:0]              y_position;
  logic [31:0]                     heading_turn;
  logic signed [11:0]              heading_tenths;

  int  fail_count;
  int  outstanding;
  bit  no_idle;
  int  words_sent;
  int  results_seen;
  int  settings_count;

  differential_drive_odometry_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .left_count(left_count),
    .right_count(right_count),
    .out_valid(out_valid), .out_ready(out_ready), .x_position(x_position),
    .y_position(y_position), .heading_turn(heading_turn),
    .heading_tenths(heading_tenths)
  );

  odometry_pose_checker u_pose_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .left_count(left_count),
    .right_count(right_count),
    .out_valid(out_valid), .out_ready(out_ready), .x_position(x_position),
    .y_position(y_position), .heading_turn(heading_turn),
    .heading_tenths(heading_tenths),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    left_count = '0;
    right_count = '0;
    out_ready = 1'b0;
    no_idle = 1'b0;
    words_sent = 0;
    results_seen = 0;
    settings_count = 0;
  end

  // run limit
  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // register write, always taken while the block is idle
  task automatic write_reg(input logic [ddo_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_count++;
  endtask

  // offer one encoder word after a random gap, valid stays up across back-to-back words
  task automatic send_word(input logic signed [15:0] l, input logic signed [15:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_count <= l;
    right_count <= r;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // stop offering and wait until every pose word has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // register value: extremes, reset value or random
  function automatic logic [23:0] pick_setting(input logic [23:0] reset_val);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return REG_MAX;
      2: return reset_val;
      3: return 24'($urandom);
      default: return 24'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic signed [15:0] corner_count;
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // pose sink with random stalls and one long hold-off
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (results_seen == HOLD_AT_RESULT && !held) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  // stimulus and verdict
  initial begin
    int                 phase;
    int                 k;
    int                 kind;
    int                 base;
    logic signed [15:0] l;
    logic signed [15:0] r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults, dropped writes past the list, extremes of the counts
    write_reg(REG_SPARE_A, 24'($urandom));
    write_reg(REG_SPARE_B, 24'($urandom));
    send_word(16'sd0, 16'sd0);
    send_word(16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff);
    send_word(16'sh7fff, 16'sh8000);
    send_word(16'sd1, -16'sd1);
    send_word(-16'sd1, 16'sd1);
    send_word(16'sd100, 16'sd300);
    drain();

    // largest travel with no turning drives the position into saturation both ways
    write_reg(ddo_pkg::REG_DISTANCE, REG_MAX);
    write_reg(ddo_pkg::REG_TURN, '0);
    repeat (3) send_word(16'sh7fff, 16'sh7fff);
    repeat (4) send_word(16'sh8000, 16'sh8000);
    drain();

    // largest turn rate makes the heading wrap
    write_reg(ddo_pkg::REG_DISTANCE, ddo_pkg::DISTANCE_RESET);
    write_reg(ddo_pkg::REG_TURN, REG_MAX);
    send_word(16'sh8000, 16'sh7fff);
    send_word(16'sh7fff, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff);
    send_word(16'sd0, 16'sd0);
    send_word(16'sd5, -16'sd7);
    drain();

    // random phases, each under its own register setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase == 3 || phase == 8);
      write_reg(ddo_pkg::REG_DISTANCE, pick_setting(ddo_pkg::DISTANCE_RESET));
      write_reg(ddo_pkg::REG_TURN, pick_setting(ddo_pkg::TURN_RESET));
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          // ordinary driving: small deltas, nearly equal wheels
          base = int'($urandom_range(0, 400)) - 200;
          l = 16'(base);
          r = 16'(base + int'($urandom_range(0, 40)) - 20);
        end else if (kind <= 7) begin
          l = 16'($urandom);
          r = 16'($urandom);
        end else if (kind == 8) begin
          l = corner_count();
          r = corner_count();
        end else begin
          l = 16'($urandom);
          r = l;
        end
        send_word(l, r);
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (40) @(posedge clk);
    $display("covered %0d encoder words and %0d pose words over %0d register writes",
             words_sent, results_seen, settings_count);
    $display("settings included zero, full scale and reset values, with a long sink stall");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> differential_drive_odometry_core.f
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_mul.sv
rtl/ddo_cordic.sv
rtl/differential_drive_odometry_core.sv
sim/odometry_pose_checker.sv
sim/testbench.sv
